// ===== hdl/dtpb_pkg.sv =====
// Shared types, constants and helper functions of the depth back-projection block.
package dtpb_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int POS_W = (COL_W > ROW_W) ? ((COL_W > 10) ? COL_W : 10)
		: ((ROW_W > 10) ? ROW_W : 10);
	localparam int OFF_W = POS_W + 5;
	localparam int PX_W = OFF_W + 17;
	localparam int PR_W = PX_W + 25;
	localparam int Q_W = PR_W - 24;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_COLOR_MODE = 3'd2;
	localparam logic [2:0] REG_INV_FOCAL_X = 3'd3;
	localparam logic [2:0] REG_INV_FOCAL_Y = 3'd4;
	localparam logic [2:0] REG_CENTER_X = 3'd5;
	localparam logic [2:0] REG_CENTER_Y = 3'd6;

	localparam logic [10:0] RST_FRAME_WIDTH = 11'd640;
	localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
	localparam logic RST_COLOR_MODE = 1'b1;
	localparam logic [23:0] RST_INV_FOCAL_X = 24'd28234;
	localparam logic [23:0] RST_INV_FOCAL_Y = 24'd28386;
	localparam logic [13:0] RST_CENTER_X = 14'd5432;
	localparam logic [13:0] RST_CENTER_Y = 14'd3883;

	// floor(255*n/2250) equals (n * 1901433) >> 24 for 0 <= n < 2250.
	localparam logic [20:0] CHAN_RECIP = 21'd1901433;
	localparam logic signed [16:0] CHAN_FULL = 17'sd2250;

	typedef struct packed {
		logic [10:0] frame_width;
		logic [10:0] frame_height;
		logic color_mode;
		logic [23:0] inv_focal_x;
		logic [23:0] inv_focal_y;
		logic [13:0] center_x_q4;
		logic [13:0] center_y_q4;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic mul1;
		logic mul2;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic nonzero;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic zero;
		logic sat;
		logic [11:0] num;
	} chan_t;

	function automatic chan_t chan_prep(input logic signed [16:0] num);
		chan_t c;
		c.zero = 1'b0;
		c.sat = 1'b0;
		c.num = num[11:0];
		if (num <= 17'sd0) begin
			c.zero = 1'b1;
		end else if (num >= CHAN_FULL) begin
			c.sat = 1'b1;
		end
		return c;
	endfunction

	function automatic logic [7:0] chan_value(input chan_t c);
		logic [32:0] p;
		p = 33'(c.num) * 33'(CHAN_RECIP);
		if (c.sat) begin
			return 8'hFF;
		end else if (c.zero) begin
			return 8'h00;
		end
		return p[31:24];
	endfunction

endpackage

// ===== hdl/dtpb_regs.sv =====
// APB configuration register file of the depth back-projection block.
module dtpb_regs
	import dtpb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= RST_FRAME_WIDTH;
			cfg_q.frame_height <= RST_FRAME_HEIGHT;
			cfg_q.color_mode <= RST_COLOR_MODE;
			cfg_q.inv_focal_x <= RST_INV_FOCAL_X;
			cfg_q.inv_focal_y <= RST_INV_FOCAL_Y;
			cfg_q.center_x_q4 <= RST_CENTER_X;
			cfg_q.center_y_q4 <= RST_CENTER_Y;
		end else if (wr_en) begin
			case (idx)
				REG_FRAME_WIDTH: cfg_q.frame_width <= pwdata[10:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[10:0];
				REG_COLOR_MODE: cfg_q.color_mode <= pwdata[0];
				REG_INV_FOCAL_X: cfg_q.inv_focal_x <= pwdata[23:0];
				REG_INV_FOCAL_Y: cfg_q.inv_focal_y <= pwdata[23:0];
				REG_CENTER_X: cfg_q.center_x_q4 <= pwdata[13:0];
				REG_CENTER_Y: cfg_q.center_y_q4 <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FRAME_WIDTH: prdata = 32'(cfg_q.frame_width);
			REG_FRAME_HEIGHT: prdata = 32'(cfg_q.frame_height);
			REG_COLOR_MODE: prdata = 32'(cfg_q.color_mode);
			REG_INV_FOCAL_X: prdata = 32'(cfg_q.inv_focal_x);
			REG_INV_FOCAL_Y: prdata = 32'(cfg_q.inv_focal_y);
			REG_CENTER_X: prdata = 32'(cfg_q.center_x_q4);
			REG_CENTER_Y: prdata = 32'(cfg_q.center_y_q4);
			default: prdata = 32'd0;
		endcase
	end

endmodule

// ===== hdl/dtpb_ctrl.sv =====
// Controller state machine that sequences one depth word through the datapath.
module dtpb_ctrl
	import dtpb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic depth_valid,
	output logic depth_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL1 = 2'd1;
	localparam logic [1:0] S_MUL2 = 2'd2;
	localparam logic [1:0] S_LOAD = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign depth_ready = (state_q == S_IDLE);
	assign cmd.accept = depth_valid && depth_ready;
	assign cmd.mul1 = (state_q == S_MUL1);
	assign cmd.mul2 = (state_q == S_MUL2);
	assign cmd.load = (state_q == S_LOAD) && sts.nonzero && sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (depth_valid) begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_LOAD;
			S_LOAD: begin
				if (!sts.nonzero || sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A zero depth word must never hold the sequencer in the load step.
	a_zero_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD && !sts.nonzero) |=> state_q == S_IDLE)
		else $error("zero depth word stalled the controller");

endmodule

// ===== hdl/dtpb_datapath.sv =====
// Datapath with pixel counters, projection multipliers, color mapping and result register.
module dtpb_datapath
	import dtpb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [15:0]         depth_mm,
	output logic                point_valid,
	input  logic                point_ready,
	output logic signed [31:0]  point_x,
	output logic signed [31:0]  point_y,
	output logic [15:0]         point_z,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W:0] width_eff;
	logic [ROW_W:0] height_eff;

	logic [15:0] z_s1;
	logic nonzero_s1;
	logic signed [OFF_W-1:0] offx_s1;
	logic signed [OFF_W-1:0] offy_s1;

	logic signed [PX_W-1:0] px_s2;
	logic signed [PX_W-1:0] py_s2;
	chan_t r_s2;
	chan_t g_s2;
	chan_t b_s2;

	logic signed [PX_W-1:0] px_full;
	logic signed [PX_W-1:0] py_full;
	logic signed [PR_W-1:0] prod_x;
	logic signed [PR_W-1:0] prod_y;
	logic signed [16:0] zs;
	chan_t r_d;
	chan_t g_d;
	chan_t b_d;

	logic out_valid_q;

	function automatic logic [31:0] sat32(input logic [Q_W-1:0] q);
		logic same;
		same = (&q[Q_W-1:31]) | ~(|q[Q_W-1:31]);
		if (same) begin
			return q[31:0];
		end
		return q[Q_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	always_comb begin
		if (cfg.frame_width == 11'd0) begin
			width_eff = (COL_W+1)'(1);
		end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
			width_eff = (COL_W+1)'(MAX_WIDTH);
		end else begin
			width_eff = (COL_W+1)'(cfg.frame_width);
		end
		if (cfg.frame_height == 11'd0) begin
			height_eff = (ROW_W+1)'(1);
		end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
			height_eff = (ROW_W+1)'(MAX_HEIGHT);
		end else begin
			height_eff = (ROW_W+1)'(cfg.frame_height);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if ({1'b0, col_q} + (COL_W+1)'(1) >= width_eff) begin
				col_q <= '0;
				if ({1'b0, row_q} + (ROW_W+1)'(1) >= height_eff) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			z_s1 <= depth_mm;
			nonzero_s1 <= (depth_mm != 16'd0);
			offx_s1 <= $signed(OFF_W'({col_q, 4'b0000})) - $signed(OFF_W'(cfg.center_x_q4));
			offy_s1 <= $signed(OFF_W'({row_q, 4'b0000})) - $signed(OFF_W'(cfg.center_y_q4));
		end
	end

	assign zs = $signed({1'b0, z_s1});
	assign px_full = offx_s1 * zs;
	assign py_full = offy_s1 * zs;

	always_comb begin
		if (!cfg.color_mode) begin
			r_d = chan_prep(CHAN_FULL);
			g_d = chan_prep(CHAN_FULL);
			b_d = chan_prep(CHAN_FULL);
		end else if (zs < 17'sd2750) begin
			r_d = chan_prep(17'sd2750 - zs);
			g_d = chan_prep(zs - 17'sd500);
			b_d = chan_prep(17'sd0);
		end else begin
			r_d = chan_prep(17'sd0);
			g_d = chan_prep(17'sd5000 - zs);
			b_d = chan_prep(zs - 17'sd2750);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			px_s2 <= px_full;
			py_s2 <= py_full;
			r_s2 <= r_d;
			g_s2 <= g_d;
			b_s2 <= b_d;
		end
	end

	assign prod_x = px_s2 * $signed({1'b0, cfg.inv_focal_x});
	assign prod_y = py_s2 * $signed({1'b0, cfg.inv_focal_y});

	logic [31:0] x_s3;
	logic [31:0] y_s3;
	logic [7:0] r_s3;
	logic [7:0] g_s3;
	logic [7:0] b_s3;

	// The arithmetic shift by 24 gives the floor of the quotient for either sign.
	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			x_s3 <= sat32(prod_x[PR_W-1:24]);
			y_s3 <= sat32(prod_y[PR_W-1:24]);
			r_s3 <= chan_value(r_s2);
			g_s3 <= chan_value(g_s2);
			b_s3 <= chan_value(b_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (point_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			point_x <= $signed(x_s3);
			point_y <= $signed(y_s3);
			point_z <= z_s1;
			red <= r_s3;
			green <= g_s3;
			blue <= b_s3;
		end
	end

	assign point_valid = out_valid_q;
	assign sts.nonzero = nonzero_s1;
	assign sts.out_free = !out_valid_q || point_ready;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || point_ready))
		else $error("result word loaded over one not yet taken");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load))
		else $error("result word shown without a load");

	a_load_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (z_s1 != 16'd0))
		else $error("zero depth word produced a point");

	a_stage_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul2 |-> $past(cmd.mul1))
		else $error("second multiply step without the first");

endmodule

// ===== hdl/depth_to_point_backprojection_unit.sv =====
// Top level of the depth image to point cloud back-projection block.
//
//  Channel   Direction  Handshake                  Word
//  depth     in         depth_valid / depth_ready  depth_mm
//  point     out        point_valid / point_ready  point_x, point_y, point_z, red, green, blue
//  config    in         APB psel/penable/pwrite    seven registers at byte address 4*i
//
// Each depth word passes through four steps: accept, first multiply, second multiply, load.
// The two chained multiplications of the projection set these steps.
// The result register lets the next word be accepted while a point waits to be taken.
// While a point stalls, at most one more nonzero word is taken; it waits in the load step.
// Reset clears the counters, the control state and the registers to their defaults.
module depth_to_point_backprojection_unit
	import dtpb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               depth_valid,
	output logic               depth_ready,
	input  logic [15:0]        depth_mm,
	output logic               point_valid,
	input  logic               point_ready,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic [15:0]        point_z,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	dtpb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dtpb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.depth_valid (depth_valid),
		.depth_ready (depth_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	dtpb_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.depth_mm    (depth_mm),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

endmodule
